[src/uvg_pkg.sv]
// Shared widths, status codes and field constants for the UUID version-7 generator.
package uvg_pkg;

  localparam int unsigned NowW   = 64;
  localparam int unsigned TimeW  = 48;
  localparam int unsigned RandAW = 12;
  localparam int unsigned RandBW = 62;
  localparam int unsigned TailW  = RandAW + RandBW;
  localparam int unsigned WordW  = 64;

  localparam logic [3:0] UuidVersion = 4'h7;
  localparam logic [1:0] UuidVariant = 2'b10;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusRange    = 2'd1,
    StatusExhaust  = 2'd2
  } status_e;

  typedef struct packed {
    logic [WordW-1:0] upper;
    logic [WordW-1:0] lower;
    status_e          status;
  } result_t;

endpackage

[src/uuid_v7_monotonic_generator.sv]
// Top level of the monotonic UUID version-7 generator.
//
// Each accepted word carries a millisecond timestamp and 74 random bits and yields exactly one
// result word via the input and result registers: a version-7 UUID, or a status of out of range
// (timestamp negative or above 2^48-1) or exhausted (stored tail all ones), both with zero UUID
// fields. A timestamp later than the stored one starts a fresh UUID; an equal or earlier one
// reissues the stored time with the stored 74-bit tail incremented by one. Unless the output
// stalls, the block takes one word per cycle: an input register feeds a single pass of compare,
// 74-bit increment and field packing into the result register, and the stored time and tail
// are updated as a word moves into the result register, so consecutive words chain without gaps.
module uuid_v7_monotonic_generator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [uvg_pkg::NowW-1:0]     now_ms_i,
  input  logic        [uvg_pkg::RandAW-1:0]   rand_a_i,
  input  logic        [uvg_pkg::RandBW-1:0]   rand_b_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic        [uvg_pkg::WordW-1:0]    uuid_upper_o,
  output logic        [uvg_pkg::WordW-1:0]    uuid_lower_o,
  output logic        [1:0]                   status_o
);

  logic                              in_valid_q;
  logic [uvg_pkg::NowW-1:0]          now_q;
  logic [uvg_pkg::RandAW-1:0]        rand_a_q;
  logic [uvg_pkg::RandBW-1:0]        rand_b_q;

  logic                              out_valid_q;
  uvg_pkg::result_t                  res_q;
  uvg_pkg::result_t                  res_d;

  logic [uvg_pkg::TimeW-1:0]         last_time_q;
  logic [uvg_pkg::TimeW-1:0]         last_time_d;
  logic [uvg_pkg::TailW-1:0]         last_tail_q;
  logic [uvg_pkg::TailW-1:0]         last_tail_d;
  logic                              have_last_q;
  logic                              have_last_d;

  logic                              out_ready;
  logic                              advance;
  logic                              take_in;
  logic                              out_of_range;
  logic                              fresh;
  logic                              exhausted;
  logic [uvg_pkg::TimeW-1:0]         now_time;
  logic [uvg_pkg::TailW-1:0]         tail_inc;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;
  assign take_in    = in_valid_i && !in_stall_o;

  assign now_time     = now_q[uvg_pkg::TimeW-1:0];
  assign out_of_range = (now_q[uvg_pkg::NowW-1:uvg_pkg::TimeW] != '0);
  assign fresh        = !have_last_q || (now_time > last_time_q);
  assign exhausted    = &last_tail_q;
  assign tail_inc     = last_tail_q + uvg_pkg::TailW'(1);

  always_comb begin
    last_time_d = last_time_q;
    last_tail_d = last_tail_q;
    have_last_d = have_last_q;
    res_d       = '{upper: '0, lower: '0, status: uvg_pkg::StatusOk};
    priority if (out_of_range) begin
      res_d.status = uvg_pkg::StatusRange;
    end else if (fresh) begin
      last_time_d = now_time;
      last_tail_d = {rand_a_q, rand_b_q};
      have_last_d = 1'b1;
    end else if (exhausted) begin
      res_d.status = uvg_pkg::StatusExhaust;
    end else begin
      last_tail_d = tail_inc;
    end
    if (res_d.status == uvg_pkg::StatusOk) begin
      res_d.upper = {last_time_d, uvg_pkg::UuidVersion,
                     last_tail_d[uvg_pkg::TailW-1:uvg_pkg::RandBW]};
      res_d.lower = {uvg_pkg::UuidVariant, last_tail_d[uvg_pkg::RandBW-1:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      last_time_q <= '0;
      last_tail_q <= '0;
      have_last_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_ready) begin
        out_valid_q <= in_valid_q;
      end
      if (advance) begin
        last_time_q <= last_time_d;
        last_tail_q <= last_tail_d;
        have_last_q <= have_last_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      now_q    <= now_ms_i;
      rand_a_q <= rand_a_i;
      rand_b_q <= rand_b_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign uuid_upper_o = res_q.upper;
  assign uuid_lower_o = res_q.lower;
  assign status_o     = res_q.status;

  a_ok_layout : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.status == uvg_pkg::StatusOk) |->
      (res_q.upper[15:12] == uvg_pkg::UuidVersion &&
       res_q.lower[uvg_pkg::WordW-1:uvg_pkg::WordW-2] == uvg_pkg::UuidVariant))
    else $error("ok result lacks version or variant bits");

  a_err_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.status != uvg_pkg::StatusOk) |->
      (res_q.upper == '0 && res_q.lower == '0))
    else $error("error result carries nonzero UUID fields");

  a_stall_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without a blocked result");

  a_have_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !out_of_range) |=> have_last_q)
    else $error("in-range word did not leave a stored UUID");

  a_state_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> ($stable(last_time_q) && $stable(last_tail_q)))
    else $error("stored state changed without a word passing");

endmodule

[tb/uuid_v7_checker.sv]
// Checker for the UUID version-7 generator: predicts each result word and compares it.
`timescale 1ns / 100ps

module uuid_v7_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  logic signed [uvg_pkg::NowW-1:0]   now_ms_i,
  input  logic        [uvg_pkg::RandAW-1:0] rand_a_i,
  input  logic        [uvg_pkg::RandBW-1:0] rand_b_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  logic        [uvg_pkg::WordW-1:0]  uuid_upper_i,
  input  logic        [uvg_pkg::WordW-1:0]  uuid_lower_i,
  input  logic        [1:0]                 status_i,
  output int                                fail_count_o,
  output int                                pending_o
);

  logic [uvg_pkg::TimeW-1:0]  stamp_q;
  logic [uvg_pkg::RandAW-1:0] tail_a_q;
  logic [uvg_pkg::RandBW-1:0] tail_b_q;
  logic                       issued_q;
  uvg_pkg::result_t           uuid_expect_q[$];

  function automatic uvg_pkg::result_t predict_uuid(
      input logic signed [uvg_pkg::NowW-1:0] now,
      input logic [uvg_pkg::RandAW-1:0] ra,
      input logic [uvg_pkg::RandBW-1:0] rb);
    uvg_pkg::result_t          res;
    logic [uvg_pkg::TailW-1:0] tail;
    res = '0;
    if (now[uvg_pkg::NowW-1:uvg_pkg::TimeW] != '0) begin
      res.status = uvg_pkg::StatusRange;
    end else if (!issued_q || now[uvg_pkg::TimeW-1:0] > stamp_q) begin
      stamp_q    = now[uvg_pkg::TimeW-1:0];
      tail_a_q   = ra;
      tail_b_q   = rb;
      issued_q   = 1'b1;
      res.upper  = {stamp_q, uvg_pkg::UuidVersion, tail_a_q};
      res.lower  = {uvg_pkg::UuidVariant, tail_b_q};
      res.status = uvg_pkg::StatusOk;
    end else if (&{tail_a_q, tail_b_q}) begin
      res.status = uvg_pkg::StatusExhaust;
    end else begin
      tail       = {tail_a_q, tail_b_q} + uvg_pkg::TailW'(1);
      tail_a_q   = tail[uvg_pkg::TailW-1:uvg_pkg::RandBW];
      tail_b_q   = tail[uvg_pkg::RandBW-1:0];
      res.upper  = {stamp_q, uvg_pkg::UuidVersion, tail_a_q};
      res.lower  = {uvg_pkg::UuidVariant, tail_b_q};
      res.status = uvg_pkg::StatusOk;
    end
    return res;
  endfunction

  task automatic compare_field(input string name, input logic [uvg_pkg::WordW-1:0] want,
                               input logic [uvg_pkg::WordW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      fail_count_o = fail_count_o + 1;
    end
  endtask

  always @(posedge clk_i) begin
    uvg_pkg::result_t want;
    uvg_pkg::result_t pred;
    if (!rst_ni) begin
      stamp_q      = '0;
      tail_a_q     = '0;
      tail_b_q     = '0;
      issued_q     = 1'b0;
      fail_count_o = 0;
      pending_o    = 0;
      uuid_expect_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (uuid_expect_q.size() == 0) begin
          $display("%0t: unexpected result word: expected none, actual %h %h status %0d",
                   $time, uuid_upper_i, uuid_lower_i, status_i);
          fail_count_o = fail_count_o + 1;
        end else begin
          want = uuid_expect_q.pop_front();
          compare_field("uuid_upper", want.upper, uuid_upper_i);
          compare_field("uuid_lower", want.lower, uuid_lower_i);
          compare_field("status", uvg_pkg::WordW'(want.status), uvg_pkg::WordW'(status_i));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        pred          = predict_uuid(now_ms_i, rand_a_i, rand_b_i);
        uuid_expect_q = {uuid_expect_q, pred};
      end
      pending_o = uuid_expect_q.size();
    end
  end

endmodule

[tb/tb_uuid_v7_monotonic_generator.sv]
// Testbench top for the UUID version-7 generator: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_uuid_v7_monotonic_generator;

  localparam int LimitCycles = 200000;
  localparam int PhaseWords  = 267;
  localparam int HoldCycles  = 80;

  logic                              clk_i;
  logic                              rst_n      = 1'b0;
  logic                              in_valid   = 1'b0;
  logic                              in_stall;
  logic signed [uvg_pkg::NowW-1:0]   now_ms     = '0;
  logic        [uvg_pkg::RandAW-1:0] rand_a     = '0;
  logic        [uvg_pkg::RandBW-1:0] rand_b     = '0;
  logic                              out_valid;
  logic                              out_stall  = 1'b0;
  logic        [uvg_pkg::WordW-1:0]  uuid_upper;
  logic        [uvg_pkg::WordW-1:0]  uuid_lower;
  logic        [1:0]                 status;

  int                        fail_count;
  int                        pending;
  int                        cycles      = 0;
  int unsigned               tx_idle_pct = 37;
  int unsigned               rx_idle_pct = 37;
  logic                      hold_req    = 1'b0;
  logic                      hold_done   = 1'b0;
  int                        hold_left   = 0;
  logic [uvg_pkg::TimeW-1:0] stamp_cur;

  uuid_v7_monotonic_generator u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .now_ms_i     (now_ms),
    .rand_a_i     (rand_a),
    .rand_b_i     (rand_b),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .uuid_upper_o (uuid_upper),
    .uuid_lower_o (uuid_lower),
    .status_o     (status)
  );

  uuid_v7_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .now_ms_i     (now_ms),
    .rand_a_i     (rand_a),
    .rand_b_i     (rand_b),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .uuid_upper_i (uuid_upper),
    .uuid_lower_i (uuid_lower),
    .status_i     (status),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LimitCycles) begin
      $display("tb: failure");
      $finish;
    end
  end

  // A single long hold-off fills the block so that it stalls its input word.
  always @(negedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HoldCycles;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(input logic signed [uvg_pkg::NowW-1:0] now,
                           input logic [uvg_pkg::RandAW-1:0] ra,
                           input logic [uvg_pkg::RandBW-1:0] rb);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    now_ms   <= now;
    rand_a   <= ra;
    rand_b   <= rb;
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
  endtask

  task automatic random_word();
    int unsigned                     pick;
    logic signed [uvg_pkg::NowW-1:0] now;
    logic [uvg_pkg::RandAW-1:0]      ra;
    logic [uvg_pkg::RandBW-1:0]      rb;
    logic [uvg_pkg::TimeW-1:0]       spread;
    pick   = $urandom_range(99);
    ra     = uvg_pkg::RandAW'($urandom_range(4095));
    rb     = uvg_pkg::RandBW'({$urandom, $urandom});
    spread = uvg_pkg::TimeW'({$urandom, $urandom});
    now    = {16'h0, stamp_cur};
    if (pick < 6) begin
      now = {$urandom, $urandom};
      if (now[uvg_pkg::NowW-1:uvg_pkg::TimeW] == '0) now[uvg_pkg::TimeW] = 1'b1;
    end else if (pick < 12) begin
      now = {16'h0, stamp_cur - uvg_pkg::TimeW'($urandom_range(1, 1000))};
    end else if (pick < 16) begin
      now = {16'h0, spread % stamp_cur};
    end else if (pick >= 50) begin
      if (pick < 53) stamp_cur = stamp_cur + uvg_pkg::TimeW'($urandom);
      else stamp_cur = stamp_cur + uvg_pkg::TimeW'($urandom_range(1, 4));
      if (pick >= 53 && pick < 62) begin
        if ($urandom_range(1) == 1) ra = {uvg_pkg::RandAW{1'b1}};
        rb = {uvg_pkg::RandBW{1'b1}} - uvg_pkg::RandBW'($urandom_range(2));
      end
      now = {16'h0, stamp_cur};
    end
    send_word(now, ra, rb);
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_n       <= 1'b1;
    rx_idle_pct <= 72;
    @(negedge clk_i);

    // Directed words: range errors, first issue, equal and backward time,
    // carry into rand_a and an exhausted tail.
    send_word(-64'sd1, 12'h000, '0);
    send_word(64'sd0, 12'h000, '0);
    send_word(64'sd0, 12'hfff, {uvg_pkg::RandBW{1'b1}});
    send_word(64'sd100, 12'h000, {uvg_pkg::RandBW{1'b1}});
    send_word(64'sd100, 12'h123, '0);
    send_word(64'sd50, 12'h000, '0);
    send_word(64'sd200, 12'hfff, {uvg_pkg::RandBW{1'b1}});
    send_word(64'sd200, 12'h000, '0);
    send_word(64'sd150, 12'h555, '0);
    send_word(64'sd201, 12'h800, 62'h2000_0000_0000_0001);
    send_word(64'sh0001_0000_0000_0000, 12'h000, '0);
    send_word(64'sh8000_0000_0000_0000, 12'hfff, {uvg_pkg::RandBW{1'b1}});
    send_word(64'sh7fff_ffff_ffff_ffff, 12'h000, '0);
    send_word(64'sh0000_ffff_ffff_ffff - 64'sd1, 12'h000, '0);
    send_word(64'sd201, 12'h000, '0);
    drain_results();

    stamp_cur = {8'h40, $urandom, 8'($urandom)};
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct = 37;
          rx_idle_pct <= 72;
        end
        1: begin
          tx_idle_pct = 72;
          rx_idle_pct <= 37;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct <= 0;
          hold_req    <= 1'b1;
        end
      endcase
      for (int n = 0; n < PhaseWords; n++) random_word();
      drain_results();
    end

    // The largest time last, since it leaves every later word at or below the stored time.
    send_word(64'sh0000_ffff_ffff_ffff, 12'habc, 62'h1555_5555_5555_5555);
    send_word(64'sh0000_ffff_ffff_ffff, 12'h000, '0);
    send_word(64'sh0001_0000_0000_0000, 12'h000, '0);
    drain_results();
    repeat (8) @(negedge clk_i);

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
